/* rtl/hilp_pkg.sv */
// hilp_pkg: types, constants and the hex digit decoder of the hex image line parser.
// No dependencies; every rtl file imports it.
package hilp_pkg;

  localparam int BYTES_PER_LINE = 32;
  localparam int END_LINE_NUM   = 11;
  localparam int HEADER_CHARS   = 8;
  localparam int FIFO_DEPTH     = 4;

  localparam int BIL_W   = $clog2(BYTES_PER_LINE + 1);
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [BIL_W-1:0] BPL       = BIL_W'(BYTES_PER_LINE);
  localparam logic [3:0]       END_LINE  = 4'(END_LINE_NUM);
  localparam logic [3:0]       HDR_SKIP  = 4'(HEADER_CHARS);
  localparam logic [3:0]       CSUM_SKIP = 4'd2;
  localparam logic [3:0]       LINE_MAX  = 4'd15;
  localparam logic [3:0]       LINE_IGN  = 4'd1;
  localparam logic [3:0]       LINE_HDR  = 4'd2;
  localparam logic [7:0]       CH_NL     = 8'h0A;
  localparam logic [7:0]       CH_COLON  = 8'h3A;
  localparam logic [7:0]       FILL_BYTE = 8'hFF;
  localparam logic [4:0]       NON_HEX   = 5'd16;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_buffer;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [8:0]  byte_index;
    logic [7:0]  byte_value;
    logic [47:0] device_id;
    logic [7:0]  image_address;
    logic [15:0] image_crc;
    logic        reached_end_line;
  } out_req_t;

  // one queue entry: at most a data byte followed by a summary
  typedef struct packed {
    logic        has_data;
    logic        has_sum;
    logic        reached;
    logic [8:0]  byte_index;
    logic [7:0]  byte_value;
    logic [47:0] device_id;
    logic [7:0]  image_address;
    logic [15:0] image_crc;
  } op_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = NON_HEX;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

/* rtl/hex_image_line_parser.sv */
// hex_image_line_parser: top level; front parser, op queue and result back end.
// Depends on hilp_pkg, hilp_front, hilp_fifo, hilp_back.
// Takes one character request per clock while the queue is not full. Each accepted
// character is parsed in its acceptance cycle and, if it yields anything, becomes
// one entry of a 4-deep queue; the back end turns each entry into one or two result
// requests through a result register, so a result passes through the queue and the
// result register. A character that yields a data byte and the summary occupies the
// result port for two requests; all others need one. No clearing pass after reset.
module hex_image_line_parser import hilp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  logic accept;
  logic push;
  logic pop;
  logic q_valid;
  op_t  op_in;
  op_t  op_head;

  assign accept = in_valid_i && in_ready_o;

  hilp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .accept_i   (accept),
    .push_o     (push),
    .op_o       (op_in)
  );

  hilp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .ready_o (in_ready_o),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (op_head)
  );

  hilp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (op_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

/* rtl/hilp_front.sv */
// hilp_front: character parser; tracks lines, skips, byte pairs and line-2 captures.
// Emits one op per character that yields a result. Depends on hilp_pkg.
module hilp_front import hilp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  in_req_t in_req_i,
  input  logic    accept_i,
  output logic    push_o,
  output op_t     op_o
);

  logic [3:0]       line_q, line_d;
  logic [3:0]       skip_q, skip_d;
  logic [BIL_W-1:0] bil_q, bil_d;
  logic [8:0]       dcnt_q, dcnt_d;
  logic             pend_q, pend_d;
  logic [4:0]       high_q, high_d;
  logic [47:0]      id_q, id_d;
  logic [7:0]       addr_q, addr_d;
  logic [15:0]      crc_q, crc_d;
  logic             done_q, done_d;

  logic [4:0] dig;
  logic [7:0] bval;
  logic [7:0] bil_w;
  logic       take;
  logic       mid_run;

  assign dig   = hex_value(in_req_i.char_in);
  assign bil_w = 8'(bil_q);

  always_comb begin
    line_d  = line_q;
    skip_d  = skip_q;
    bil_d   = bil_q;
    dcnt_d  = dcnt_q;
    pend_d  = pend_q;
    high_d  = high_q;
    id_d    = id_q;
    addr_d  = addr_q;
    crc_d   = crc_q;
    done_d  = done_q;
    op_o    = '0;
    take    = 1'b0;
    bval    = 8'h00;
    mid_run = pend_q || (bil_q != '0 && bil_q < BPL);

    if (accept_i && !done_q) begin
      if (skip_q != 4'd0) begin
        skip_d = skip_q - 4'd1;
      end else if (mid_run) begin
        take = 1'b1;
      end else if (in_req_i.char_in == CH_NL) begin
        if (line_q < LINE_MAX) begin
          line_d = line_q + 4'd1;
        end
      end else if (line_q == LINE_IGN) begin
        line_d = line_q;
      end else if (line_q == END_LINE) begin
        op_o.has_sum = 1'b1;
        op_o.reached = 1'b1;
        done_d       = 1'b1;
      end else if (in_req_i.char_in == CH_COLON) begin
        skip_d = HDR_SKIP;
      end else if (bil_q >= BPL) begin
        bil_d  = '0;
        skip_d = CSUM_SKIP;
      end else begin
        take = 1'b1;
      end

      if (take) begin
        if (!pend_q) begin
          high_d = dig;
          pend_d = 1'b1;
        end else begin
          if (high_q == NON_HEX) begin
            bval = 8'h00;
          end else if (dig == NON_HEX) begin
            bval = {4'h0, high_q[3:0]};
          end else begin
            bval = {high_q[3:0], dig[3:0]};
          end
          op_o.has_data   = 1'b1;
          op_o.byte_index = dcnt_q;
          op_o.byte_value = bval;
          if (line_q == LINE_HDR) begin
            for (int i = 0; i < 6; i++) begin
              if (bil_w == 8'(i)) begin
                id_d[(5-i)*8 +: 8] = bval;
              end
            end
            if (bil_w < 8'd9) begin
              op_o.byte_value = FILL_BYTE;
            end
            if (bil_w == 8'd8) begin
              addr_d = bval;
            end
            if (bil_w == 8'd9) begin
              crc_d[7:0] = bval;
            end
            if (bil_w == 8'd10) begin
              crc_d[15:8] = bval;
            end
          end
          dcnt_d = dcnt_q + 9'd1;
          bil_d  = bil_q + BIL_W'(1);
          pend_d = 1'b0;
        end
      end

      if (in_req_i.end_of_buffer && !op_o.has_sum) begin
        op_o.has_sum = 1'b1;
        op_o.reached = 1'b0;
      end
      op_o.device_id     = id_d;
      op_o.image_address = addr_d;
      op_o.image_crc     = crc_d;
    end

    if (accept_i && in_req_i.end_of_buffer) begin
      line_d = LINE_IGN;
      skip_d = 4'd0;
      bil_d  = '0;
      dcnt_d = 9'd0;
      pend_d = 1'b0;
      high_d = 5'd0;
      id_d   = 48'd0;
      addr_d = 8'd0;
      crc_d  = 16'd0;
      done_d = 1'b0;
    end
  end

  assign push_o = accept_i && (op_o.has_data || op_o.has_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LINE_IGN;
      skip_q <= 4'd0;
      bil_q  <= '0;
      dcnt_q <= 9'd0;
      pend_q <= 1'b0;
      high_q <= 5'd0;
      id_q   <= 48'd0;
      addr_q <= 8'd0;
      crc_q  <= 16'd0;
      done_q <= 1'b0;
    end else begin
      line_q <= line_d;
      skip_q <= skip_d;
      bil_q  <= bil_d;
      dcnt_q <= dcnt_d;
      pend_q <= pend_d;
      high_q <= high_d;
      id_q   <= id_d;
      addr_q <= addr_d;
      crc_q  <= crc_d;
      done_q <= done_d;
    end
  end

  a_bil_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bil_q <= BPL)
    else $error("byte_in_line past line length");

  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= HDR_SKIP || skip_q <= CSUM_SKIP)
    else $error("skip count out of range");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !(in_valid_i && in_req_i.end_of_buffer) |-> !push_o)
    else $error("request produced after image end");

endmodule

/* rtl/hilp_fifo.sv */
// hilp_fifo: short op queue between the parser front and the output back end.
// Flip-flop storage, one write and one read port. Depends on hilp_pkg.
module hilp_fifo import hilp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  op_t              mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o = cnt_q != CNT_W'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("queue count overflow");

endmodule

/* rtl/hilp_back.sv */
// hilp_back: drains queued ops into the registered result port, data byte first.
// Depends on hilp_pkg.
module hilp_back import hilp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     op_valid_i,
  input  op_t      op_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  logic     vld_q, vld_d;
  logic     sent_q, sent_d;
  out_req_t res_q, res_d;
  logic     load;

  assign load = !vld_q || out_ready_i;

  always_comb begin
    vld_d  = vld_q;
    sent_d = sent_q;
    res_d  = res_q;
    pop_o  = 1'b0;
    if (load) begin
      vld_d = op_valid_i;
      if (op_valid_i) begin
        res_d = '0;
        if (op_i.has_data && !sent_q) begin
          res_d.kind       = KIND_DATA;
          res_d.byte_index = op_i.byte_index;
          res_d.byte_value = op_i.byte_value;
          if (op_i.has_sum) begin
            sent_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          res_d.kind             = KIND_SUMMARY;
          res_d.device_id        = op_i.device_id;
          res_d.image_address    = op_i.image_address;
          res_d.image_crc        = op_i.image_crc;
          res_d.reached_end_line = op_i.reached;
          sent_d                 = 1'b0;
          pop_o                  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      sent_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      sent_q <= sent_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_req_o   = res_q;

  a_sent_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q |-> op_valid_i && op_i.has_data && op_i.has_sum)
    else $error("split entry lost from queue head");

endmodule
